// ===== hdl/pcx_rle_image_decoder_unit_defines.svh =====
// Assertion helpers shared by the decoder modules.
// Each one is used inside a module that has clk and rst_n in scope.
`ifndef PCX_RLE_IMAGE_DECODER_UNIT_DEFINES_SVH
`define PCX_RLE_IMAGE_DECODER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PCXRLE_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define PCXRLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pcxrle_pkg.sv =====
`default_nettype none

package pcxrle_pkg;

    localparam logic [7:0] RUN_BASE     = 8'd192;
    localparam logic [7:0] PALETTE_MARK = 8'd12;
    localparam logic [6:0] HEADER_LAST  = 7'd127;
    localparam logic [9:0] PALETTE_LEN  = 10'd768;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_PIXELS  = 3'd1,
        PH_MARKER  = 3'd2,
        PH_PALETTE = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PIXEL    = 3'd0,
        KIND_PALETTE  = 3'd1,
        KIND_DIMS     = 3'd2,
        KIND_HDR_ERR  = 3'd3,
        KIND_MARK_ERR = 3'd4,
        KIND_OVERFLOW = 3'd5
    } res_kind_t;

    // One queued job for the back end. Pixel jobs repeat value count times;
    // every other kind gives exactly one result.
    typedef struct packed {
        res_kind_t   kind;
        logic [7:0]  value;
        logic [31:0] position;
        logic [16:0] width;
        logic [16:0] height;
        logic [5:0]  count;
    } cmd_t;

    // Signature bytes at the head of the header.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'd10;
            2'd1:    b = 8'd5;
            2'd2:    b = 8'd1;
            default: b = 8'd8;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pcxrle_front.sv =====
`default_nettype none

module pcxrle_front
    import pcxrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    phase_t      phase_reg, phase_next;
    logic [6:0]  hcnt_reg, hcnt_next;
    logic [16:0] width_reg, width_next;
    logic [16:0] height_reg, height_next;
    logic [16:0] row_reg, row_next;
    logic [16:0] col_reg, col_next;
    logic        run_pend_reg, run_pend_next;
    logic [5:0]  run_len_reg, run_len_next;
    logic [9:0]  pal_reg, pal_next;

    // state as seen by this byte: a file start clears it first
    phase_t      phase_eff;
    logic [6:0]  hcnt_eff;
    logic [16:0] width_eff, height_eff, row_eff, col_eff;
    logic        run_pend_eff;
    logic [5:0]  run_len_eff;
    logic [9:0]  pal_eff;

    logic        accept;
    logic [5:0]  step;
    logic [16:0] col_sum;
    logic [16:0] row_inc;
    logic [9:0]  pal_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg    <= PH_HEADER;
            hcnt_reg     <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            run_pend_reg <= 1'b0;
            run_len_reg  <= '0;
            pal_reg      <= '0;
        end
        else begin
            phase_reg    <= phase_next;
            hcnt_reg     <= hcnt_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            run_pend_reg <= run_pend_next;
            run_len_reg  <= run_len_next;
            pal_reg      <= pal_next;
        end
    end

    always_comb begin
        phase_eff    = in_start ? PH_HEADER : phase_reg;
        hcnt_eff     = in_start ? 7'd0 : hcnt_reg;
        width_eff    = in_start ? 17'd0 : width_reg;
        height_eff   = in_start ? 17'd0 : height_reg;
        row_eff      = in_start ? 17'd0 : row_reg;
        col_eff      = in_start ? 17'd0 : col_reg;
        run_pend_eff = in_start ? 1'b0 : run_pend_reg;
        run_len_eff  = in_start ? 6'd0 : run_len_reg;
        pal_eff      = in_start ? 10'd0 : pal_reg;

        step    = run_pend_eff ? run_len_eff : 6'd1;
        col_sum = col_eff + {11'd0, step};
        row_inc = row_eff + 17'd1;
        pal_inc = pal_eff + 10'd1;

        phase_next    = phase_reg;
        hcnt_next     = hcnt_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        run_pend_next = run_pend_reg;
        run_len_next  = run_len_reg;
        pal_next      = pal_reg;

        q_push         = 1'b0;
        q_cmd.kind     = KIND_PIXEL;
        q_cmd.value    = in_byte;
        q_cmd.position = '0;
        q_cmd.width    = '0;
        q_cmd.height   = '0;
        q_cmd.count    = 6'd1;

        if (accept) begin
            phase_next    = phase_eff;
            hcnt_next     = hcnt_eff;
            width_next    = width_eff;
            height_next   = height_eff;
            row_next      = row_eff;
            col_next      = col_eff;
            run_pend_next = run_pend_eff;
            run_len_next  = run_len_eff;
            pal_next      = pal_eff;

            unique case (phase_eff)
                PH_HEADER: begin
                    if (hcnt_eff[6:2] == 5'd0 && in_byte != magic_byte(hcnt_eff[1:0])) begin
                        q_push         = 1'b1;
                        q_cmd.kind     = KIND_HDR_ERR;
                        q_cmd.position = {25'd0, hcnt_eff};
                        phase_next     = PH_ERROR;
                    end
                    else begin
                        case (hcnt_eff)
                            7'd8:    width_next  = {1'b0, width_eff[15:8], in_byte};
                            7'd9:    width_next  = {1'b0, in_byte, width_eff[7:0]};
                            7'd10:   height_next = {1'b0, height_eff[15:8], in_byte};
                            7'd11:   height_next = {1'b0, in_byte, height_eff[7:0]};
                            default: ;
                        endcase
                        if (hcnt_eff == HEADER_LAST) begin
                            width_next   = {1'b0, width_eff[15:0]} + 17'd1;
                            height_next  = {1'b0, height_eff[15:0]} + 17'd1;
                            q_push       = 1'b1;
                            q_cmd.kind   = KIND_DIMS;
                            q_cmd.value  = '0;
                            q_cmd.width  = width_next;
                            q_cmd.height = height_next;
                            phase_next   = PH_PIXELS;
                            row_next     = '0;
                            col_next     = '0;
                        end
                        hcnt_next = hcnt_eff + 7'd1;
                    end
                end
                PH_PIXELS: begin
                    if (!run_pend_eff && in_byte > RUN_BASE) begin
                        // run count byte; the count is the low six bits
                        run_pend_next = 1'b1;
                        run_len_next  = in_byte[5:0];
                    end
                    else begin
                        q_push        = 1'b1;
                        q_cmd.count   = step;
                        run_pend_next = 1'b0;
                        col_next      = col_sum;
                        // row end is judged once the whole run is placed
                        if (col_sum >= width_eff) begin
                            col_next = '0;
                            row_next = row_inc;
                            if (row_inc >= height_eff) begin
                                phase_next = PH_MARKER;
                            end
                        end
                    end
                end
                PH_MARKER: begin
                    if (in_byte != PALETTE_MARK) begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_MARK_ERR;
                    end
                    phase_next = PH_PALETTE;
                    pal_next   = '0;
                end
                PH_PALETTE: begin
                    q_push         = 1'b1;
                    q_cmd.kind     = KIND_PALETTE;
                    q_cmd.position = {22'd0, pal_eff};
                    pal_next       = pal_inc;
                    if (pal_inc >= PALETTE_LEN) begin
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pcxrle_cmd_fifo.sv =====
`default_nettype none

`include "pcx_rle_image_decoder_unit_defines.svh"

module pcxrle_cmd_fifo
    import pcxrle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;

    assign full     = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    `PCXRLE_ASSERT(a_no_overflow, !(push && full), "command queue written while full")
    `PCXRLE_ASSERT(a_no_underflow, !(pop && empty), "command queue read while empty")
    `PCXRLE_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not advance")

endmodule

`default_nettype wire

// ===== hdl/pcxrle_back.sv =====
`default_nettype none

`include "pcx_rle_image_decoder_unit_defines.svh"

module pcxrle_back
    import pcxrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    output logic        q_pop,
    input  cmd_t        q_head,
    output logic        out_valid,
    input  logic        out_ready,
    output res_kind_t   out_kind,
    output logic [7:0]  out_value,
    output logic [31:0] out_position,
    output logic [16:0] out_width,
    output logic [16:0] out_height,
    output logic        out_last
);

    cmd_t        cur_reg;
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] pos_reg;
    logic [32:0] total_reg;
    logic        ov_reg;
    res_kind_t   okind_reg;
    logic [7:0]  oval_reg;
    logic [31:0] opos_reg;
    logic [16:0] ow_reg, oh_reg;
    logic        olast_reg;

    logic        load;
    logic        final_one;
    logic [32:0] area;
    res_kind_t   pix_kind;

    assign load      = busy_reg && (!ov_reg || out_ready);
    assign final_one = (cnt_reg == 6'd1);
    assign q_pop     = !q_empty && (!busy_reg || (load && final_one));
    assign area      = {16'd0, cur_reg.width} * {16'd0, cur_reg.height};
    assign pix_kind  = ({1'b0, pos_reg} >= total_reg) ? KIND_OVERFLOW : KIND_PIXEL;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else begin
            if (load) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cur_reg.kind == KIND_PIXEL) begin
                    pos_reg <= pos_reg + 32'd1;
                end
                else if (cur_reg.kind == KIND_DIMS) begin
                    pos_reg   <= '0;
                    total_reg <= area;
                end
                if (final_one) begin
                    busy_reg <= 1'b0;
                end
            end
            if (q_pop) begin
                busy_reg <= 1'b1;
                cnt_reg  <= q_head.count;
            end
            if (load) begin
                ov_reg <= 1'b1;
            end
            else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (load) begin
            okind_reg <= (cur_reg.kind == KIND_PIXEL) ? pix_kind : cur_reg.kind;
            oval_reg  <= cur_reg.value;
            opos_reg  <= (cur_reg.kind == KIND_PIXEL) ? pos_reg : cur_reg.position;
            ow_reg    <= cur_reg.width;
            oh_reg    <= cur_reg.height;
            olast_reg <= final_one;
        end
    end

    assign out_valid    = ov_reg;
    assign out_kind     = okind_reg;
    assign out_value    = oval_reg;
    assign out_position = opos_reg;
    assign out_width    = ow_reg;
    assign out_height   = oh_reg;
    assign out_last     = olast_reg;

    `PCXRLE_ASSERT(a_busy_count, !busy_reg || cnt_reg != 6'd0, "active job with no results left")
    `PCXRLE_ASSERT_NEXT(a_dims_restart, load && cur_reg.kind == KIND_DIMS, pos_reg == 32'd0,
                        "pixel index not cleared by dimensions")

endmodule

`default_nettype wire

// ===== hdl/pcx_rle_image_decoder_unit.sv =====
// PCX 8-bit run-length image decoder. Feed the file one byte per transfer on the s_ side,
// with s_tuser high on the first byte of each file. The 128-byte header is checked
// (bytes 0..3 must read 10, 5, 1, 8); a mismatch yields one header-error result and the
// rest of the file is ignored. After the header one dimensions result carries width and
// height (header bytes 8..11 plus one). Pixel data then expand into one result per pixel,
// tagged as overflow when the linear index reaches width*height. A wrong palette marker
// gives one marker-error result, and the 768 palette bytes follow as palette results.
// m_tlast marks the final result caused by one input byte. A run count byte produces
// nothing, and the run data byte then makes the back end give one result per pixel
// (1 to 63). The front end keeps taking bytes until the 4-entry job queue between the
// two halves fills, so input stalls are set by run lengths and by m_tready. No clearing
// pass after reset; the block takes bytes as soon as reset is released.
`default_nettype none

module pcx_rle_image_decoder_unit
    import pcxrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] value, [39:8] position, [56:40] image_width,
                                   // [73:57] image_height, [79:74] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last result of the input byte
);

    // front end to queue
    logic q_push;
    cmd_t q_in_cmd;
    logic q_full;

    // queue to back end
    logic q_pop;
    logic q_empty;
    cmd_t q_head;

    res_kind_t   out_kind;
    logic [7:0]  out_value;
    logic [31:0] out_position;
    logic [16:0] out_width;
    logic [16:0] out_height;

    // Parses the header, tracks rows/columns and phase, one job per byte at most.
    pcxrle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_start (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    // Short job queue so a long run does not hold up parsing right away.
    pcxrle_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Expands runs, numbers pixels, judges overflow, drives the output register.
    pcxrle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_head       (q_head),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (out_kind),
        .out_value    (out_value),
        .out_position (out_position),
        .out_width    (out_width),
        .out_height   (out_height),
        .out_last     (m_tlast)
    );

    assign m_tdata = {6'd0, out_height, out_width, out_position, out_value};
    assign m_tuser = out_kind;

endmodule

`default_nettype wire
